// ===== hdl/uhe_pkg.sv =====
// uhe_pkg: shared types of the utf-8 html entity escaper
// token kinds and the token that the front pushes to the back through the queue
// no dependencies
package uhe_pkg;

  localparam int unsigned CP_W = 21;

  typedef enum logic [2:0] {
    K_MARK,
    K_COPY,
    K_LT,
    K_GT,
    K_AMP,
    K_QUOT,
    K_APOS,
    K_DEC
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [3:0][7:0] seq;
    logic [2:0]      len;
    logic [CP_W-1:0] cp;
    logic [2:0]      pstart;
    logic            item_end;
    logic            str_end;
  } tok_t;

endpackage

// ===== hdl/uhe_front.sv =====
// uhe_front: input side of the escaper; gathers utf-8 sequences, decodes and classifies them
// pushes up to one token per cycle into the queue, none while it is full; flushes cut-off sequences at string end
// depends on uhe_pkg
module uhe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data,
  input  logic              in_present,
  input  logic              in_last,
  output logic              push,
  output uhe_pkg::tok_t     tok,
  input  logic              full
);

  typedef struct packed {
    logic       found;
    logic [1:0] pos;
    logic [2:0] k;
  } scan_t;

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] k;
    k = 3'd0;
    if ((c & 8'h80) == 8'h00) k = 3'd1;
    else if ((c & 8'hE0) == 8'hC0) k = 3'd2;
    else if ((c & 8'hF0) == 8'hE0) k = 3'd3;
    else if ((c & 8'hF8) == 8'hF0) k = 3'd4;
    return k;
  endfunction

  function automatic scan_t first_seq(input logic [3:0][7:0] b, input logic [2:0] n);
    scan_t      r;
    logic [2:0] k;
    r = '0;
    for (int i = 3; i >= 0; i--) begin
      k = seq_len(b[i]);
      if (k != 3'd0 && (3'(i) + k) <= n) begin
        r.found = 1'b1;
        r.pos   = 2'(i);
        r.k     = k;
      end
    end
    return r;
  endfunction

  function automatic logic [uhe_pkg::CP_W-1:0] decode(input logic [3:0][7:0] b,
                                                      input logic [2:0] k);
    logic [uhe_pkg::CP_W-1:0] cp;
    case (k)
      3'd1:    cp = {13'd0, b[0]};
      3'd2:    cp = {10'd0, b[0][4:0], b[1][5:0]};
      3'd3:    cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
      default: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
    endcase
    return cp;
  endfunction

  logic                     busy;
  logic [1:0]               hcnt;
  logic [2:0][7:0]          held;
  logic [3:0][7:0]          wb;
  logic [2:0]               wlen;

  logic                     acc;
  logic                     flush;
  logic [3:0][7:0]          nb;
  logic [2:0]               nlen;
  logic [2:0]               k0;
  logic [3:0][7:0]          src;
  logic [2:0]               slen;
  scan_t                    f1;
  scan_t                    f2;
  logic [2:0]               adv;
  logic [3:0][7:0]          rest;
  logic [2:0]               restlen;
  logic                     more;
  logic [3:0][7:0]          seqsel;
  logic [2:0]               ksel;
  logic [uhe_pkg::CP_W-1:0] cp;

  assign in_ready = !busy && !full;
  assign acc      = in_valid && in_ready;
  assign flush    = busy || in_last;

  always_comb begin
    nb = '0;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < hcnt) nb[j] = held[j];
    end
    nb[hcnt] = in_data;
  end

  assign nlen    = {1'b0, hcnt} + {2'b00, in_present};
  assign k0      = seq_len(nb[0]);
  assign src     = busy ? wb : nb;
  assign slen    = busy ? wlen : nlen;
  assign f1      = first_seq(src, slen);
  assign adv     = {1'b0, f1.pos} + f1.k;
  assign rest    = src >> {adv, 3'b000};
  assign restlen = slen - adv;
  assign f2      = first_seq(rest, restlen);
  assign more    = f1.found && f2.found;
  assign seqsel  = flush ? (src >> {f1.pos, 3'b000}) : nb;
  assign ksel    = flush ? f1.k : k0;
  assign cp      = decode(seqsel, ksel);

  always_comb begin
    push = 1'b0;
    if (busy) begin
      push = !full;
    end else if (acc) begin
      if (in_last) push = 1'b1;
      else if (in_present && k0 != 3'd0 && nlen == k0) push = 1'b1;
    end
  end

  always_comb begin
    tok.seq      = seqsel;
    tok.len      = ksel;
    tok.cp       = cp;
    tok.item_end = flush ? !more : 1'b1;
    tok.str_end  = flush ? !more : 1'b0;
    if (cp >= 21'd1000000) tok.pstart = 3'd6;
    else if (cp >= 21'd100000) tok.pstart = 3'd5;
    else tok.pstart = 3'd4;
    if (flush && !f1.found) tok.kind = uhe_pkg::K_MARK;
    else if (cp == 21'h00003C) tok.kind = uhe_pkg::K_LT;
    else if (cp == 21'h00003E) tok.kind = uhe_pkg::K_GT;
    else if (cp == 21'h000026) tok.kind = uhe_pkg::K_AMP;
    else if (cp == 21'h000022) tok.kind = uhe_pkg::K_QUOT;
    else if (cp == 21'h000027) tok.kind = uhe_pkg::K_APOS;
    else if (cp <= 21'h00FFFF) tok.kind = uhe_pkg::K_COPY;
    else tok.kind = uhe_pkg::K_DEC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      hcnt <= 2'd0;
    end else if (busy) begin
      if (!full && !more) busy <= 1'b0;
    end else if (acc) begin
      if (in_last) begin
        hcnt <= 2'd0;
        busy <= more;
      end else if (in_present && k0 != 3'd0) begin
        hcnt <= (nlen == k0) ? 2'd0 : nlen[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy ? !full : (acc && in_last)) begin
      wb   <= rest;
      wlen <= restlen;
    end
    if (acc && !in_last && in_present) held <= nb[2:0];
  end

  // a held sequence is always unfinished
  assert property (@(posedge clk) disable iff (rst)
    hcnt != 2'd0 |-> seq_len(held[0]) > {1'b0, hcnt})
    else $error("held bytes form a complete or bad sequence");

  assert property (@(posedge clk) disable iff (rst)
    busy |-> hcnt == 2'd0 && f1.found && push == !full)
    else $error("flush without a pending sequence");

  assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

endmodule

// ===== hdl/uhe_fifo.sv =====
// uhe_fifo: short token queue between the front and the back of the escaper
// register storage, combinational read of the head entry
// depends on uhe_pkg
module uhe_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uhe_pkg::tok_t wdata,
  output logic          full,
  input  logic          pop,
  output uhe_pkg::tok_t rdata,
  output logic          valid
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  uhe_pkg::tok_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] cnt;

  assign full  = cnt == CW'(DEPTH);
  assign valid = cnt != '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("queue count out of range");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> valid)
    else $error("pushed entry lost");

endmodule

// ===== hdl/uhe_back.sv =====
// uhe_back: output side of the escaper; expands queued tokens into output beats
// copies bytes, spells entities, and writes decimal references one digit per beat
// depends on uhe_pkg
module uhe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  uhe_pkg::tok_t tok,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tlast,
  output logic [1:0]    m_tuser
);

  function automatic logic [uhe_pkg::CP_W-1:0] pow10(input logic [2:0] p);
    logic [uhe_pkg::CP_W-1:0] v;
    case (p)
      3'd0:    v = 21'd1;
      3'd1:    v = 21'd10;
      3'd2:    v = 21'd100;
      3'd3:    v = 21'd1000;
      3'd4:    v = 21'd10000;
      3'd5:    v = 21'd100000;
      3'd6:    v = 21'd1000000;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] ent_char(input uhe_pkg::kind_t k, input logic [2:0] i);
    logic [47:0] s;
    logic [47:0] t;
    unique case (k) inside
      uhe_pkg::K_LT:   s = {"&lt;", 16'h0000};
      uhe_pkg::K_GT:   s = {"&gt;", 16'h0000};
      uhe_pkg::K_AMP:  s = {"&amp;", 8'h00};
      uhe_pkg::K_QUOT: s = "&quot;";
      uhe_pkg::K_APOS: s = {"&#39;", 8'h00};
      default:         s = '0;
    endcase
    t = s << {i, 3'b000};
    return t[47:40];
  endfunction

  function automatic logic [3:0] beats(input uhe_pkg::tok_t t);
    logic [3:0] n;
    unique case (t.kind) inside
      uhe_pkg::K_MARK:                 n = 4'd1;
      uhe_pkg::K_COPY:                 n = {1'b0, t.len};
      uhe_pkg::K_LT, uhe_pkg::K_GT:    n = 4'd4;
      uhe_pkg::K_AMP, uhe_pkg::K_APOS: n = 4'd5;
      uhe_pkg::K_QUOT:                 n = 4'd6;
      uhe_pkg::K_DEC:                  n = {1'b0, t.pstart} + 4'd4;
      default:                         n = 4'd1;
    endcase
    return n;
  endfunction

  logic                     active;
  uhe_pkg::kind_t           kind;
  logic [3:0][7:0]          seq;
  logic [uhe_pkg::CP_W-1:0] rem;
  logic [2:0]               p;
  logic                     item_end;
  logic                     str_end;
  logic [3:0]               idx;
  logic [3:0]               lastidx;

  logic                     is_last;
  logic                     out_free;
  logic                     fire;
  logic                     digit_beat;
  logic [uhe_pkg::CP_W-1:0] pw;
  logic [3:0]               d;
  logic [24:0]              sub;
  logic [7:0]               bb;
  logic                     bv;

  assign is_last    = idx == lastidx;
  assign out_free   = !m_tvalid || m_tready;
  assign fire       = active && out_free;
  assign q_pop      = q_valid && (!active || (fire && is_last));
  assign digit_beat = kind == uhe_pkg::K_DEC && idx >= 4'd2 && !is_last;
  assign pw         = pow10(p);

  always_comb begin
    d = 4'd0;
    for (int m = 1; m <= 9; m++) begin
      if ({4'd0, rem} >= 25'(m) * {4'd0, pw}) d = 4'(m);
    end
    sub = {21'd0, d} * {4'd0, pw};
  end

  always_comb begin
    bv = 1'b1;
    unique case (kind) inside
      uhe_pkg::K_MARK: begin
        bb = 8'h00;
        bv = 1'b0;
      end
      uhe_pkg::K_COPY: bb = seq[idx[1:0]];
      uhe_pkg::K_DEC: begin
        if (idx == 4'd0) bb = "&";
        else if (idx == 4'd1) bb = "#";
        else if (is_last) bb = ";";
        else bb = "0" + {4'd0, d};
      end
      default: bb = ent_char(kind, idx[2:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) active <= 1'b1;
      else if (fire && is_last) active <= 1'b0;
      if (fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= bb;
      m_tlast <= is_last && item_end;
      m_tuser <= {is_last && str_end, bv};
      if (!q_pop) idx <= idx + 4'd1;
      if (digit_beat) begin
        rem <= rem - sub[uhe_pkg::CP_W-1:0];
        p   <= p - 3'd1;
      end
    end
    if (q_pop) begin
      kind     <= tok.kind;
      seq      <= tok.seq;
      rem      <= tok.cp;
      p        <= tok.pstart;
      item_end <= tok.item_end;
      str_end  <= tok.str_end;
      idx      <= 4'd0;
      lastidx  <= beats(tok) - 4'd1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && m_tdata == 8'h00)
    else $error("bare end beat with stray fields");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("string end without run end");

  assert property (@(posedge clk) disable iff (rst)
    fire && !is_last |=> active && idx == $past(idx) + 4'd1)
    else $error("token expansion cut short");

endmodule

// ===== hdl/utf8_html_entity_escaper.sv =====
// Escapes a UTF-8 byte stream for HTML: < > & " ' become named or numeric entities,
// codepoints up to 0xFFFF copy their bytes, larger ones become &#decimal; references.
// Sequences are sized from the lead byte alone. Bad lead bytes are dropped; at string
// end a cut-off sequence loses its lead byte and the bytes after it are decoded again.
// One input beat is taken per cycle unless the front is busy or the queue is full;
// the output side sends one byte per cycle while the sink is ready. At a string end
// the front holds the input while it pushes each further sequence recovered from a
// cut-off tail (at most one). A token queue of QUEUE_DEPTH entries sits between
// decoding and expansion; each token passes the queue, the back's token registers
// and then the output register.
// depends on uhe_pkg, uhe_front, uhe_fifo, uhe_back
module utf8_html_entity_escaper #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tuser,   // byte_present
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [1:0] m_tuser,   // byte_valid, string_end
  output logic       m_tlast
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  uhe_pkg::tok_t q_wdata;
  uhe_pkg::tok_t q_rdata;

  uhe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_present (s_tuser),
    .in_last    (s_tlast),
    .push       (q_push),
    .tok        (q_wdata),
    .full       (q_full)
  );

  uhe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  uhe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .tok      (q_rdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
